// ===== src/pcdg_pkg.sv =====
// shared types and constants for the periodic central difference gradient core
package pcdg_pkg;

   // field widths
   localparam int PIXEL_W = 16;
   localparam int GRAD_W  = 17;
   localparam int COORD_W = 8;
   localparam int SIDE_W  = 9;

   // storage defaults
   localparam int               MAX_SIDE_DEFAULT = 256;
   localparam logic [SIDE_W-1:0] SIDE_RESET      = 9'd256;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // which pixel around the current position the address generator points at
   typedef enum logic [2:0] {
      NBR_CENTRE,
      NBR_RIGHT,
      NBR_LEFT,
      NBR_DOWN,
      NBR_UP
   } nbr_sel_type;

   // pixel memory strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ===== src/pcdg_pixel_ram.sv =====
// single-port pixel memory with registered read data
module pcdg_pixel_ram #(
   parameter int MAX_SIDE = pcdg_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                                      clock,
   input  pcdg_pkg::mem_ctl_type                     mem_ctl,
   input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]      addr,
   input  logic signed [pcdg_pkg::PIXEL_W-1:0]       wr_data,
   output logic signed [pcdg_pkg::PIXEL_W-1:0]       rd_data
);

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;

   logic signed [pcdg_pkg::PIXEL_W-1:0] mem_ff [DEPTH];
   logic signed [pcdg_pkg::PIXEL_W-1:0] rd_data_ff;

   // one access a cycle, read data held until the next read
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pcdg_nbr.sv =====
// neighbour coordinate wrap and pixel address generation
module pcdg_nbr #(
   parameter int MAX_SIDE = pcdg_pkg::MAX_SIDE_DEFAULT
) (
   input  logic [pcdg_pkg::SIDE_W-1:0]               side,
   input  logic [pcdg_pkg::COORD_W-1:0]              row,
   input  logic [pcdg_pkg::COORD_W-1:0]              col,
   input  pcdg_pkg::nbr_sel_type                     sel,
   output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]      addr
);

   localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int SW = pcdg_pkg::SIDE_W;

   logic [SW-1:0] row_ext;
   logic [SW-1:0] col_ext;
   logic [SW-1:0] last;
   logic [SW-1:0] col_left;
   logic [SW-1:0] col_right;
   logic [SW-1:0] row_up;
   logic [SW-1:0] row_down;
   logic [SW-1:0] nbr_row;
   logic [SW-1:0] nbr_col;

   // periodic wrap at all four borders
   always_comb begin
      row_ext   = {1'b0, row};
      col_ext   = {1'b0, col};
      last      = side - SW'(1);
      col_left  = (col_ext == '0) ? last : col_ext - SW'(1);
      col_right = (col_ext + SW'(1) == side) ? '0 : col_ext + SW'(1);
      row_up    = (row_ext == '0) ? last : row_ext - SW'(1);
      row_down  = (row_ext + SW'(1) == side) ? '0 : row_ext + SW'(1);
   end

   // pick the neighbour for this step
   always_comb begin
      nbr_row = row_ext;
      nbr_col = col_ext;
      unique case (sel)
         pcdg_pkg::NBR_CENTRE: begin
            nbr_row = row_ext;
            nbr_col = col_ext;
         end
         pcdg_pkg::NBR_RIGHT: begin
            nbr_col = col_right;
         end
         pcdg_pkg::NBR_LEFT: begin
            nbr_col = col_left;
         end
         pcdg_pkg::NBR_DOWN: begin
            nbr_row = row_down;
         end
         pcdg_pkg::NBR_UP: begin
            nbr_row = row_up;
         end
         default: begin
            nbr_row = row_ext;
            nbr_col = col_ext;
         end
      endcase
   end

   // row-major address, row times the storage side plus column
   assign addr = AW'(AW'(nbr_row) * AW'(MAX_SIDE) + AW'(nbr_col));

endmodule

// ===== src/pcdg_seq.sv =====
// command sequencer with the shared difference unit and result register
module pcdg_seq (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [pcdg_pkg::SIDE_W-1:0]            side,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_command,
   input  logic [pcdg_pkg::COORD_W-1:0]           req_row,
   input  logic [pcdg_pkg::COORD_W-1:0]           req_col,
   input  logic signed [pcdg_pkg::PIXEL_W-1:0]    req_pixel_value,
   output pcdg_pkg::mem_ctl_type                  mem_ctl,
   output pcdg_pkg::nbr_sel_type                  sel,
   output logic [pcdg_pkg::COORD_W-1:0]           row,
   output logic [pcdg_pkg::COORD_W-1:0]           col,
   output logic signed [pcdg_pkg::PIXEL_W-1:0]    wr_data,
   input  logic signed [pcdg_pkg::PIXEL_W-1:0]    rd_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [pcdg_pkg::GRAD_W-1:0]     rsp_grad_x_doubled,
   output logic signed [pcdg_pkg::GRAD_W-1:0]     rsp_grad_y_doubled
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_RIGHT,
      S_LEFT,
      S_DOWN,
      S_UP,
      S_FIN
   } state_type;

   state_type                            state_ff, state_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [pcdg_pkg::COORD_W-1:0]         row_ff, row_in;
   logic [pcdg_pkg::COORD_W-1:0]         col_ff, col_in;
   logic signed [pcdg_pkg::PIXEL_W-1:0]  pix_ff, pix_in;
   logic signed [pcdg_pkg::PIXEL_W-1:0]  hold_ff, hold_in;
   logic signed [pcdg_pkg::GRAD_W-1:0]   gx_ff, gx_in;
   logic signed [pcdg_pkg::GRAD_W-1:0]   out_x_ff, out_x_in;
   logic signed [pcdg_pkg::GRAD_W-1:0]   out_y_ff, out_y_in;
   logic signed [pcdg_pkg::GRAD_W-1:0]   diff;
   logic                                 req_take;
   logic                                 in_range;
   logic                                 out_free;

   // shared difference unit: held sample minus the sample just read
   assign diff = {hold_ff[pcdg_pkg::PIXEL_W-1], hold_ff}
               - {rd_data[pcdg_pkg::PIXEL_W-1], rd_data};

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign in_range  = ({1'b0, req_row} < side) && ({1'b0, req_col} < side);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state and datapath register loads
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      row_in       = row_ff;
      col_in       = col_ff;
      pix_in       = pix_ff;
      hold_in      = hold_ff;
      gx_in        = gx_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      mem_ctl      = '0;
      sel          = pcdg_pkg::NBR_CENTRE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               row_in = req_row;
               col_in = req_col;
               pix_in = req_pixel_value;
               if (in_range) begin
                  state_in = (req_command == pcdg_pkg::CMD_QUERY) ? S_RIGHT : S_WRITE;
               end
            end
         end
         S_WRITE: begin
            mem_ctl.wr_en = 1'b1;
            sel           = pcdg_pkg::NBR_CENTRE;
            state_in      = S_IDLE;
         end
         S_RIGHT: begin
            mem_ctl.rd_en = 1'b1;
            sel           = pcdg_pkg::NBR_RIGHT;
            state_in      = S_LEFT;
         end
         S_LEFT: begin
            mem_ctl.rd_en = 1'b1;
            sel           = pcdg_pkg::NBR_LEFT;
            hold_in       = rd_data;
            state_in      = S_DOWN;
         end
         S_DOWN: begin
            mem_ctl.rd_en = 1'b1;
            sel           = pcdg_pkg::NBR_DOWN;
            gx_in         = diff;
            state_in      = S_UP;
         end
         S_UP: begin
            mem_ctl.rd_en = 1'b1;
            sel           = pcdg_pkg::NBR_UP;
            hold_in       = rd_data;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               out_x_in     = gx_ff;
               out_y_in     = diff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff   <= row_in;
      col_ff   <= col_in;
      pix_ff   <= pix_in;
      hold_ff  <= hold_in;
      gx_ff    <= gx_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
   end

   assign row                = row_ff;
   assign col                = col_ff;
   assign wr_data            = pix_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_grad_x_doubled = out_x_ff;
   assign rsp_grad_y_doubled = out_y_ff;

   // a finished query waits while the result register is still full
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) && !out_free |=> (state_ff == S_FIN))
      else $error("finished query left before the result register was free");

   // a new result only appears out of the final step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result raised outside the final step");

   // single port: never a read and a write together
   assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr_en && mem_ctl.rd_en))
      else $error("pixel memory read and written in one cycle");

   // an in-range query starts its neighbour reads at once
   assert property (@(posedge clock) disable iff (reset)
      req_take && in_range && (req_command == pcdg_pkg::CMD_QUERY)
      |=> (state_ff == S_RIGHT))
      else $error("accepted query did not start its reads");

   // an out-of-range command leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      req_take && !in_range |=> (state_ff == S_IDLE))
      else $error("out-of-range command was not dropped");

endmodule

// ===== src/periodic_central_difference_gradient_core.sv =====
// top level of the periodic central difference gradient core
//
// Holds a square image of signed 16-bit pixels in a single-port memory and
// answers gradient queries with periodic wrap at all four borders.
// req channel: command 0 writes req_pixel_value at (req_row, req_col),
// command 1 queries; both accepted when req_valid and req_ready are high.
// rsp channel: one transaction per in-range query, carrying right minus
// left and lower minus upper neighbour, i.e. twice the gradient.
// Commands with a coordinate at or beyond the side give no transaction.
// csr channel: writes the image side; always ready, write only while idle.
// A query is accepted, reads its four neighbours through the one memory
// port (right, left, down, up), then forms the final difference; a write is
// accepted and then written, and an out-of-range command is dropped. No new
// command is taken until the block is idle again. One subtractor serves both.
// Reset sets the side to 256 and empties the result register; pixel
// contents are undefined until written and are not cleared.
// A stalled receiver holds the result; writes are still accepted, and the
// next query waits in its last step until the result is taken.
module periodic_central_difference_gradient_core #(
   parameter int MAX_SIDE = pcdg_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pcdg_pkg::SIDE_W-1:0]            csr_image_side,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_command,
   input  logic [pcdg_pkg::COORD_W-1:0]           req_row,
   input  logic [pcdg_pkg::COORD_W-1:0]           req_col,
   input  logic signed [pcdg_pkg::PIXEL_W-1:0]    req_pixel_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [pcdg_pkg::GRAD_W-1:0]     rsp_grad_x_doubled,
   output logic signed [pcdg_pkg::GRAD_W-1:0]     rsp_grad_y_doubled
);

   localparam int AW    = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int SW    = pcdg_pkg::SIDE_W;
   localparam int CMP_W = $clog2(MAX_SIDE + 1) + SW;

   logic [SW-1:0]                        image_side_ff, image_side_in;
   logic [SW-1:0]                        side;
   pcdg_pkg::mem_ctl_type                mem_ctl;
   pcdg_pkg::nbr_sel_type                sel;
   logic [pcdg_pkg::COORD_W-1:0]         row;
   logic [pcdg_pkg::COORD_W-1:0]         col;
   logic [AW-1:0]                        addr;
   logic signed [pcdg_pkg::PIXEL_W-1:0]  wr_data;
   logic signed [pcdg_pkg::PIXEL_W-1:0]  rd_data;

   // side register
   assign csr_ready     = 1'b1;
   assign image_side_in = (csr_valid && csr_ready) ? csr_image_side : image_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_side_ff <= pcdg_pkg::SIDE_RESET;
      end else begin
         image_side_ff <= image_side_in;
      end
   end

   // side saturates at the storage side
   assign side = (CMP_W'(image_side_ff) > CMP_W'(MAX_SIDE)) ? SW'(MAX_SIDE) : image_side_ff;

   pcdg_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .side               (side),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_pixel_value    (req_pixel_value),
      .mem_ctl            (mem_ctl),
      .sel                (sel),
      .row                (row),
      .col                (col),
      .wr_data            (wr_data),
      .rd_data            (rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_grad_x_doubled (rsp_grad_x_doubled),
      .rsp_grad_y_doubled (rsp_grad_y_doubled)
   );

   pcdg_nbr #(
      .MAX_SIDE (MAX_SIDE)
   ) u_nbr (
      .side (side),
      .row  (row),
      .col  (col),
      .sel  (sel),
      .addr (addr)
   );

   pcdg_pixel_ram #(
      .MAX_SIDE (MAX_SIDE)
   ) u_ram (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .addr    (addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the periodic central difference gradient core
module testbench;

   localparam int STORE_SIDE    = pcdg_pkg::MAX_SIDE_DEFAULT;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 40;
   localparam int PIXEL_W       = pcdg_pkg::PIXEL_W;
   localparam int GRAD_W        = pcdg_pkg::GRAD_W;
   localparam int COORD_W       = pcdg_pkg::COORD_W;
   localparam int SIDE_W        = pcdg_pkg::SIDE_W;

   typedef struct {
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
   } gradient_pair_type;

   logic                       clock;
   logic                       reset           = 1'b1;
   logic                       csr_valid       = 1'b0;
   logic                       csr_ready;
   logic [SIDE_W-1:0]          csr_image_side  = '0;
   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic                       req_command     = pcdg_pkg::CMD_WRITE;
   logic [COORD_W-1:0]         req_row         = '0;
   logic [COORD_W-1:0]         req_col         = '0;
   logic signed [PIXEL_W-1:0]  req_pixel_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b0;
   logic signed [GRAD_W-1:0]   rsp_grad_x_doubled;
   logic signed [GRAD_W-1:0]   rsp_grad_y_doubled;

   // image model: pixel contents, which pixels hold data, and the side in use
   logic signed [PIXEL_W-1:0]  image_pixels [0:STORE_SIDE*STORE_SIDE-1];
   bit                         pixel_written [0:STORE_SIDE*STORE_SIDE-1];
   logic [SIDE_W-1:0]          model_side = pcdg_pkg::SIDE_RESET;

   gradient_pair_type          gradient_q [$];
   int                         mismatch_count  = 0;
   int                         items_in_range  = 0;
   int                         stall_left      = 0;
   bit                         steady_flow     = 1'b0;

   periodic_central_difference_gradient_core uut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_image_side     (csr_image_side),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_pixel_value    (req_pixel_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_grad_x_doubled (rsp_grad_x_doubled),
      .rsp_grad_y_doubled (rsp_grad_y_doubled)
   );

   // clock, period 10
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // side in use, saturated to the store size
   function automatic int active_side();
      return (model_side > STORE_SIDE) ? STORE_SIDE : int'(model_side);
   endfunction

   function automatic int wrap_prev(int p, int s);
      return (p == 0) ? s - 1 : p - 1;
   endfunction

   function automatic int wrap_next(int p, int s);
      return (p + 1 == s) ? 0 : p + 1;
   endfunction

   // mostly random samples, now and then the two extremes
   function automatic logic signed [PIXEL_W-1:0] random_pixel();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      return PIXEL_W'($urandom());
   endfunction

   // update the image model for one accepted command, queue any gradient
   function automatic void apply_to_image(logic cmd, int r, int c,
                                          logic signed [PIXEL_W-1:0] pix);
      int                s;
      gradient_pair_type g;
      s = active_side();
      if (r >= s || c >= s)
         return;
      if (cmd == pcdg_pkg::CMD_WRITE) begin
         image_pixels[r*STORE_SIDE+c]  = pix;
         pixel_written[r*STORE_SIDE+c] = 1'b1;
      end else begin
         g.grad_x = GRAD_W'(int'(image_pixels[r*STORE_SIDE+wrap_next(c, s)])
                          - int'(image_pixels[r*STORE_SIDE+wrap_prev(c, s)]));
         g.grad_y = GRAD_W'(int'(image_pixels[wrap_next(r, s)*STORE_SIDE+c])
                          - int'(image_pixels[wrap_prev(r, s)*STORE_SIDE+c]));
         gradient_q.push_back(g);
      end
   endfunction

   // receiver: random stall bursts unless running at full rate
   always @(negedge clock) begin
      if (steady_flow) begin
         rsp_ready = 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready  = 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready  = 1'b0;
         stall_left = $urandom_range(1, 13) - 1;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // compare each result transaction with the oldest expected gradient
   always @(posedge clock) begin : result_check
      gradient_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (gradient_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual x %0d y %0d",
                     $time, rsp_grad_x_doubled, rsp_grad_y_doubled);
            mismatch_count++;
         end else begin
            want = gradient_q.pop_front();
            if (rsp_grad_x_doubled !== want.grad_x) begin
               $display("%0t: grad_x_doubled mismatch, expected %0d, actual %0d",
                        $time, want.grad_x, rsp_grad_x_doubled);
               mismatch_count++;
            end
            if (rsp_grad_y_doubled !== want.grad_y) begin
               $display("%0t: grad_y_doubled mismatch, expected %0d, actual %0d",
                        $time, want.grad_y, rsp_grad_y_doubled);
               mismatch_count++;
            end
         end
      end
   end

   // one command transaction, with an optional idle burst ahead of it
   task automatic send_command(logic cmd, int r, int c, logic signed [PIXEL_W-1:0] pix);
      int gap;
      if (!steady_flow && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_command     = cmd;
      req_row         = COORD_W'(r);
      req_col         = COORD_W'(c);
      req_pixel_value = pix;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (r < active_side() && c < active_side())
         items_in_range++;
      apply_to_image(cmd, r, c, pix);
   endtask

   // query, first filling in any neighbour that holds no data yet
   task automatic query_at(int r, int c);
      int s;
      int nr[4];
      int nc[4];
      s = active_side();
      if (r < s && c < s) begin
         nr = '{r, r, wrap_next(r, s), wrap_prev(r, s)};
         nc = '{wrap_next(c, s), wrap_prev(c, s), c, c};
         for (int k = 0; k < 4; k++)
            if (!pixel_written[nr[k]*STORE_SIDE+nc[k]])
               send_command(pcdg_pkg::CMD_WRITE, nr[k], nc[k], random_pixel());
      end
      send_command(pcdg_pkg::CMD_QUERY, r, c, random_pixel());
   endtask

   // stop sending, wait for every gradient, then let the block settle
   task automatic wait_results_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (gradient_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // change the image side while the block is idle
   task automatic set_side(logic [SIDE_W-1:0] side_value);
      wait_results_drained();
      @(negedge clock);
      csr_valid      = 1'b1;
      csr_image_side = side_value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      model_side = side_value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // mostly well-formed queries, some writes, some out-of-range noise
   task automatic random_item();
      int s;
      int pick;
      int r;
      int c;
      s    = active_side();
      pick = $urandom_range(0, 99);
      if (s < STORE_SIDE && pick >= 88) begin
         if ($urandom_range(0, 1)) begin
            r = $urandom_range(s, 255);
            c = $urandom_range(0, 255);
         end else begin
            r = $urandom_range(0, 255);
            c = $urandom_range(s, 255);
         end
         send_command($urandom_range(0, 1) ? pcdg_pkg::CMD_QUERY : pcdg_pkg::CMD_WRITE,
                      r, c, random_pixel());
      end else begin
         r = $urandom_range(0, s - 1);
         c = $urandom_range(0, s - 1);
         if (pick < 70)
            query_at(r, c);
         else
            send_command(pcdg_pkg::CMD_WRITE, r, c, random_pixel());
      end
   endtask

   task automatic run_random_items(int count);
      int target;
      target = items_in_range + count;
      while (items_in_range < target)
         random_item();
   endtask

   // reset side, largest differences of both signs and wrap at the corners
   task automatic test_reset_side();
      send_command(pcdg_pkg::CMD_WRITE, 0, 1, 16'sh7fff);
      send_command(pcdg_pkg::CMD_WRITE, 0, 255, 16'sh8000);
      send_command(pcdg_pkg::CMD_WRITE, 1, 0, 16'sh8000);
      send_command(pcdg_pkg::CMD_WRITE, 255, 0, 16'sh7fff);
      query_at(0, 0);
      query_at(255, 255);
   endtask

   // smallest side, and commands beyond it
   task automatic test_smallest_side();
      set_side(2);
      send_command(pcdg_pkg::CMD_WRITE, 0, 0, 16'sh7fff);
      send_command(pcdg_pkg::CMD_WRITE, 0, 1, 16'sh8000);
      send_command(pcdg_pkg::CMD_WRITE, 1, 0, 16'sh8000);
      send_command(pcdg_pkg::CMD_WRITE, 1, 1, 16'sh0001);
      query_at(1, 1);
      query_at(0, 1);
      send_command(pcdg_pkg::CMD_WRITE, 2, 0, 16'sh1234);
      send_command(pcdg_pkg::CMD_QUERY, 0, 2, 16'sh0000);
      send_command(pcdg_pkg::CMD_QUERY, 255, 255, 16'sh0000);
   endtask

   // side of one, side of zero and a side above the store size
   task automatic test_degenerate_sides();
      set_side(1);
      query_at(0, 0);
      send_command(pcdg_pkg::CMD_WRITE, 1, 0, 16'sh5555);
      set_side(0);
      send_command(pcdg_pkg::CMD_WRITE, 0, 0, 16'shaaaa);
      send_command(pcdg_pkg::CMD_QUERY, 0, 0, 16'sh0000);
      set_side(511);
      query_at(0, 0);
   endtask

   function automatic logic [SIDE_W-1:0] side_for_phase(int p);
      case (p)
         0:       return 9'd2;
         1:       return 9'd256;
         2:       return SIDE_W'($urandom_range(3, 20));
         3:       return SIDE_W'($urandom_range(3, 20));
         4:       return SIDE_W'($urandom_range(21, 255));
         5:       return 9'd511;
         6:       return SIDE_W'($urandom_range(257, 510));
         default: return SIDE_W'($urandom_range(2, 8));
      endcase
   endfunction

   // random traffic over a range of image sides
   task automatic test_random_phases();
      for (int p = 0; p < 8; p++) begin
         set_side(side_for_phase(p));
         run_random_items(PHASE_ITEMS);
      end
   endtask

   // sender holds off until every gradient has come back, then resumes
   task automatic test_pause_until_drained();
      set_side(SIDE_W'($urandom_range(4, 12)));
      run_random_items(12);
      wait_results_drained();
      run_random_items(12);
   endtask

   // no idling on either side to finish
   task automatic test_full_rate();
      set_side(SIDE_W'($urandom_range(2, 16)));
      steady_flow = 1'b1;
      run_random_items(60);
   endtask

   initial begin : run
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_side();
      test_smallest_side();
      test_degenerate_sides();
      test_random_phases();
      test_pause_until_drained();
      test_full_rate();
      wait_results_drained();
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // overall time limit
   initial begin : watchdog
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/pcdg_pkg.sv
src/pcdg_pixel_ram.sv
src/pcdg_nbr.sv
src/pcdg_seq.sv
src/periodic_central_difference_gradient_core.sv
test/testbench.sv
